>>> hw/rtl/c8lsu_pkg.sv
// Shared types, constants and the cycle cost table of the 8-bit load/store unit.
`default_nettype none
package c8lsu_pkg;

   localparam int MEM_ADDR_BITS_DEFAULT = 16;
   localparam int NUM_REGS = 7;
   localparam int Q_DEPTH = 2;

   localparam logic [2:0] REG_B = 3'd0;
   localparam logic [2:0] REG_C = 3'd1;
   localparam logic [2:0] REG_D = 3'd2;
   localparam logic [2:0] REG_E = 3'd3;
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_A = 3'd6;

   typedef enum logic [3:0] {
      OP_LD_RR     = 4'd0,
      OP_LD_R_HL   = 4'd1,
      OP_LD_HL_R   = 4'd2,
      OP_LD_R_IMM  = 4'd3,
      OP_LD_HL_IMM = 4'd4,
      OP_LD_BC_A   = 4'd5,
      OP_LD_DE_A   = 4'd6,
      OP_LD_NN_A   = 4'd7,
      OP_LD_A_BC   = 4'd8,
      OP_LD_A_DE   = 4'd9,
      OP_LD_A_NN   = 4'd10,
      OP_POKE      = 4'd11,
      OP_PEEK      = 4'd12,
      OP_SETPC     = 4'd13,
      OP_SETREG    = 4'd14
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [15:0] addr;
      logic [7:0]  wval;
      logic [2:0]  cost;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   function automatic logic [2:0] op_cost(input op_type op);
      logic [2:0] c;
      case (op) inside
         OP_LD_RR:                                   c = 3'd1;
         OP_LD_R_HL, OP_LD_HL_R, OP_LD_R_IMM,
         OP_LD_BC_A, OP_LD_DE_A, OP_LD_A_BC,
         OP_LD_A_DE:                                 c = 3'd2;
         OP_LD_HL_IMM:                               c = 3'd3;
         OP_LD_NN_A, OP_LD_A_NN:                     c = 3'd4;
         default:                                    c = 3'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/c8lsu_front.sv
// Front end: takes requests, decodes the operation and its cost, pushes into the queue.
`default_nettype none
module c8lsu_front (
   input  wire logic                   start,
   input  wire logic [3:0]             req_op,
   input  wire logic [2:0]             req_dest_reg,
   input  wire logic [2:0]             req_src_reg,
   input  wire logic [15:0]            req_mem_address,
   input  wire logic [7:0]             req_write_value,
   input  wire c8lsu_pkg::q_status_type q_status,
   output logic                        busy,
   output logic                        push,
   output c8lsu_pkg::cmd_type          cmd
);

   c8lsu_pkg::op_type op_dec;

   always_comb begin
      op_dec   = c8lsu_pkg::op_type'(req_op);
      busy     = q_status.full;
      push     = start && !q_status.full;
      cmd.op   = op_dec;
      cmd.dst  = req_dest_reg;
      cmd.src  = req_src_reg;
      cmd.addr = req_mem_address;
      cmd.wval = req_write_value;
      cmd.cost = c8lsu_pkg::op_cost(op_dec);
   end

endmodule
`default_nettype wire

>>> hw/rtl/c8lsu_queue.sv
// Short FIFO of decoded requests between the front end and the back end.
`default_nettype none
module c8lsu_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire c8lsu_pkg::cmd_type      push_cmd,
   input  wire logic                    pop,
   output c8lsu_pkg::q_status_type      q_status,
   output c8lsu_pkg::cmd_type           head_cmd
);

   localparam int PW = (c8lsu_pkg::Q_DEPTH > 1) ? $clog2(c8lsu_pkg::Q_DEPTH) : 1;
   localparam int CW = $clog2(c8lsu_pkg::Q_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(c8lsu_pkg::Q_DEPTH);
   localparam logic [PW-1:0] LAST_C  = PW'(c8lsu_pkg::Q_DEPTH - 1);

   c8lsu_pkg::cmd_type slot_ff [c8lsu_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      q_status.valid = (count_ff != '0);
      q_status.full  = (count_ff == DEPTH_C);
      head_cmd       = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/c8lsu_back.sv
// Back end: register file, program counter, byte memory and the execution sequencer.
`default_nettype none
module c8lsu_back #(
   parameter int MEM_ADDR_BITS = c8lsu_pkg::MEM_ADDR_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire c8lsu_pkg::q_status_type q_status,
   input  wire c8lsu_pkg::cmd_type      head_cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_reg_b,
   output logic [7:0]                   rsp_reg_c,
   output logic [7:0]                   rsp_reg_d,
   output logic [7:0]                   rsp_reg_e,
   output logic [7:0]                   rsp_reg_h,
   output logic [7:0]                   rsp_reg_l,
   output logic [7:0]                   rsp_reg_a,
   output logic [15:0]                  rsp_prog_counter,
   output logic [7:0]                   rsp_peek_data,
   output logic [2:0]                   rsp_machine_cycles
);

   localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_RD
   } state_type;

   state_type          state_ff, state_in;
   c8lsu_pkg::cmd_type cmd_ff, cmd_in, cur;
   logic [7:0]         rf_ff [c8lsu_pkg::NUM_REGS];
   logic [7:0]         rf_in [c8lsu_pkg::NUM_REGS];
   logic [15:0]        pc_ff, pc_in;
   logic [7:0]         lo_ff, lo_in;
   logic [7:0]         peek_ff, peek_in;
   logic [2:0]         cyc_ff, cyc_in;
   logic               valid_ff, valid_in;

   logic [7:0]         mem [MEM_DEPTH];
   logic [7:0]         mem_rdata_ff;
   logic [15:0]        mem_a;
   logic [7:0]         mem_wd;
   logic               mem_we;

   logic               reg_we;
   logic [2:0]         reg_idx;
   logic [7:0]         reg_wd;
   logic [7:0]         src_val;
   logic [15:0]        hl, bc, de;
   logic               done;

   always_comb begin
      hl = {rf_ff[c8lsu_pkg::REG_H], rf_ff[c8lsu_pkg::REG_L]};
      bc = {rf_ff[c8lsu_pkg::REG_B], rf_ff[c8lsu_pkg::REG_C]};
      de = {rf_ff[c8lsu_pkg::REG_D], rf_ff[c8lsu_pkg::REG_E]};

      state_in = state_ff;
      cmd_in   = cmd_ff;
      cur      = cmd_ff;
      pc_in    = pc_ff;
      lo_in    = lo_ff;
      peek_in  = 8'd0;
      cyc_in   = cyc_ff;
      valid_in = 1'b0;
      pop      = 1'b0;
      done     = 1'b0;
      mem_a    = pc_ff;
      mem_wd   = rf_ff[c8lsu_pkg::REG_A];
      mem_we   = 1'b0;
      reg_we   = 1'b0;
      reg_idx  = cmd_ff.dst;
      reg_wd   = mem_rdata_ff;

      case (state_ff)
         ST_IDLE: begin
            cur     = head_cmd;
            reg_idx = head_cmd.dst;
            if (q_status.valid) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.op)
                  c8lsu_pkg::OP_LD_RR: begin
                     reg_we = 1'b1;
                     reg_wd = src_val;
                     done   = 1'b1;
                  end
                  c8lsu_pkg::OP_LD_R_HL: begin
                     mem_a    = hl;
                     state_in = ST_RD;
                  end
                  c8lsu_pkg::OP_LD_HL_R: begin
                     mem_a  = hl;
                     mem_wd = src_val;
                     mem_we = 1'b1;
                     done   = 1'b1;
                  end
                  c8lsu_pkg::OP_LD_R_IMM, c8lsu_pkg::OP_LD_HL_IMM: begin
                     pc_in    = pc_ff + 16'd1;
                     state_in = ST_RD;
                  end
                  c8lsu_pkg::OP_LD_BC_A: begin
                     mem_a  = bc;
                     mem_we = 1'b1;
                     done   = 1'b1;
                  end
                  c8lsu_pkg::OP_LD_DE_A: begin
                     mem_a  = de;
                     mem_we = 1'b1;
                     done   = 1'b1;
                  end
                  c8lsu_pkg::OP_LD_NN_A, c8lsu_pkg::OP_LD_A_NN: begin
                     pc_in    = pc_ff + 16'd1;
                     state_in = ST_LO;
                  end
                  c8lsu_pkg::OP_LD_A_BC: begin
                     mem_a    = bc;
                     state_in = ST_RD;
                  end
                  c8lsu_pkg::OP_LD_A_DE: begin
                     mem_a    = de;
                     state_in = ST_RD;
                  end
                  c8lsu_pkg::OP_POKE: begin
                     mem_a  = head_cmd.addr;
                     mem_wd = head_cmd.wval;
                     mem_we = 1'b1;
                     done   = 1'b1;
                  end
                  c8lsu_pkg::OP_PEEK: begin
                     mem_a    = head_cmd.addr;
                     state_in = ST_RD;
                  end
                  c8lsu_pkg::OP_SETPC: begin
                     pc_in = head_cmd.addr;
                     done  = 1'b1;
                  end
                  c8lsu_pkg::OP_SETREG: begin
                     reg_we = 1'b1;
                     reg_wd = head_cmd.wval;
                     done   = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_LO: begin
            // Low address byte is back; fetch the high byte at the advanced PC.
            lo_in    = mem_rdata_ff;
            pc_in    = pc_ff + 16'd1;
            state_in = ST_HI;
         end
         ST_HI: begin
            mem_a = {mem_rdata_ff, lo_ff};
            if (cmd_ff.op == c8lsu_pkg::OP_LD_NN_A) begin
               mem_we   = 1'b1;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            case (cmd_ff.op) inside
               c8lsu_pkg::OP_LD_R_HL, c8lsu_pkg::OP_LD_R_IMM: begin
                  reg_we = 1'b1;
               end
               c8lsu_pkg::OP_LD_HL_IMM: begin
                  mem_a  = hl;
                  mem_wd = mem_rdata_ff;
                  mem_we = 1'b1;
               end
               c8lsu_pkg::OP_LD_A_BC, c8lsu_pkg::OP_LD_A_DE, c8lsu_pkg::OP_LD_A_NN: begin
                  reg_we  = 1'b1;
                  reg_idx = c8lsu_pkg::REG_A;
               end
               c8lsu_pkg::OP_PEEK: begin
                  peek_in = mem_rdata_ff;
               end
               default: begin
               end
            endcase
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         valid_in = 1'b1;
         cyc_in   = cur.cost;
      end

      for (int i = 0; i < c8lsu_pkg::NUM_REGS; i++) begin
         rf_in[i] = rf_ff[i];
      end
      // Destination seven is not a register, so the write is dropped.
      if (reg_we && (reg_idx < 3'(c8lsu_pkg::NUM_REGS))) begin
         rf_in[reg_idx] = reg_wd;
      end
   end

   always_comb begin
      src_val = (head_cmd.src < 3'(c8lsu_pkg::NUM_REGS)) ? rf_ff[head_cmd.src] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         pc_ff    <= 16'd0;
         peek_ff  <= 8'd0;
         cyc_ff   <= 3'd0;
         for (int i = 0; i < c8lsu_pkg::NUM_REGS; i++) begin
            rf_ff[i] <= 8'd0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pc_ff    <= pc_in;
         if (done) begin
            peek_ff <= peek_in;
         end
         cyc_ff <= cyc_in;
         for (int i = 0; i < c8lsu_pkg::NUM_REGS; i++) begin
            rf_ff[i] <= rf_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      lo_ff  <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a[MEM_ADDR_BITS-1:0]] <= mem_wd;
      end
      mem_rdata_ff <= mem[mem_a[MEM_ADDR_BITS-1:0]];
   end

   always_comb begin
      rsp_valid          = valid_ff;
      rsp_reg_b          = rf_ff[c8lsu_pkg::REG_B];
      rsp_reg_c          = rf_ff[c8lsu_pkg::REG_C];
      rsp_reg_d          = rf_ff[c8lsu_pkg::REG_D];
      rsp_reg_e          = rf_ff[c8lsu_pkg::REG_E];
      rsp_reg_h          = rf_ff[c8lsu_pkg::REG_H];
      rsp_reg_l          = rf_ff[c8lsu_pkg::REG_L];
      rsp_reg_a          = rf_ff[c8lsu_pkg::REG_A];
      rsp_prog_counter   = pc_ff;
      rsp_peek_data      = peek_ff;
      rsp_machine_cycles = cyc_ff;
   end

endmodule
`default_nettype wire

>>> hw/rtl/cpu_8bit_load_store_unit_core.sv
// Top level of the 8-bit load/store unit: front end, request queue and back end.
`default_nettype none
// Usage:
//   A request (req_op, req_dest_reg, req_src_reg, req_mem_address, req_write_value)
//   is taken at a rising edge where start is high and busy is low. Decoded requests
//   wait in a two-entry queue; busy is high while that queue is full.
//   Each request yields exactly one result, shown for one cycle with rsp_valid high:
//   all seven byte registers, the program counter, the peeked byte and the cost
//   in machine cycles. The receiver cannot stall; results appear in request order.
//   The back end executes one request at a time on a single-port byte memory with
//   registered read data. Register copies, stores through a register pair, pokes, setpc
//   and setreg finish in the idle state; any single memory read adds the read state;
//   a store to an absolute address passes through the low and high address byte states,
//   and a load from one adds the read state after those. The memory port takes one
//   access per cycle. The result is shown in the cycle after the last back-end state;
//   an idle block first moves an accepted request through the registered queue.
//   Synchronous reset clears the registers, the program counter and the queue;
//   memory contents are not cleared and must be written before they are read.
module cpu_8bit_load_store_unit_core #(
   parameter int MEM_ADDR_BITS = c8lsu_pkg::MEM_ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_op,
   input  wire logic [2:0]  req_dest_reg,
   input  wire logic [2:0]  req_src_reg,
   input  wire logic [15:0] req_mem_address,
   input  wire logic [7:0]  req_write_value,
   output logic             rsp_valid,
   output logic [7:0]       rsp_reg_b,
   output logic [7:0]       rsp_reg_c,
   output logic [7:0]       rsp_reg_d,
   output logic [7:0]       rsp_reg_e,
   output logic [7:0]       rsp_reg_h,
   output logic [7:0]       rsp_reg_l,
   output logic [7:0]       rsp_reg_a,
   output logic [15:0]      rsp_prog_counter,
   output logic [7:0]       rsp_peek_data,
   output logic [2:0]       rsp_machine_cycles
);

   c8lsu_pkg::q_status_type q_status;
   c8lsu_pkg::cmd_type      push_cmd;
   c8lsu_pkg::cmd_type      head_cmd;
   logic                    push;
   logic                    pop;

   c8lsu_front u_front (
      .start           (start),
      .req_op          (req_op),
      .req_dest_reg    (req_dest_reg),
      .req_src_reg     (req_src_reg),
      .req_mem_address (req_mem_address),
      .req_write_value (req_write_value),
      .q_status        (q_status),
      .busy            (busy),
      .push            (push),
      .cmd             (push_cmd)
   );

   c8lsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   c8lsu_back #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_reg_b          (rsp_reg_b),
      .rsp_reg_c          (rsp_reg_c),
      .rsp_reg_d          (rsp_reg_d),
      .rsp_reg_e          (rsp_reg_e),
      .rsp_reg_h          (rsp_reg_h),
      .rsp_reg_l          (rsp_reg_l),
      .rsp_reg_a          (rsp_reg_a),
      .rsp_prog_counter   (rsp_prog_counter),
      .rsp_peek_data      (rsp_peek_data),
      .rsp_machine_cycles (rsp_machine_cycles)
   );

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("result or busy right after reset");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("back end popped an empty queue");

   a_peek_is_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_peek_data != 8'd0)) |-> (rsp_machine_cycles == 3'd0))
      else $error("peeked byte reported on a costed instruction");

   a_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_machine_cycles <= 3'd4))
      else $error("machine cycle cost out of range");

endmodule
`default_nettype wire

>>> dv/cpu_8bit_load_store_unit_core_tb.sv
// Self-checking testbench for the 8-bit load/store unit: directed and random requests.
`timescale 1ns / 100ps
module cpu_8bit_load_store_unit_core_tb;

   localparam int MEM_BITS = c8lsu_pkg::MEM_ADDR_BITS_DEFAULT;
   localparam int MEM_SIZE = 1 << MEM_BITS;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam logic [2:0] REG_NONE = 3'd7;
   // The stimulus planner and the checker each keep their own copy of the CPU state.
   localparam int PLAN = 0;
   localparam int LIVE = 1;

   typedef struct packed {
      logic [3:0]  op;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [15:0] addr;
      logic [7:0]  wval;
   } ls_req_type;

   typedef struct packed {
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [7:0]  a;
      logic [15:0] pc;
      logic [7:0]  peek;
      logic [2:0]  cycles;
   } ls_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   ls_req_type  req_cur = '0;
   logic        busy;
   logic        rsp_valid;
   logic [7:0]  rsp_reg_b, rsp_reg_c, rsp_reg_d, rsp_reg_e, rsp_reg_h, rsp_reg_l, rsp_reg_a;
   logic [15:0] rsp_prog_counter;
   logic [7:0]  rsp_peek_data;
   logic [2:0]  rsp_machine_cycles;

   logic [7:0]  reg_img [2][7];
   logic [15:0] pc_img [2];
   logic [7:0]  mem_img [2][MEM_SIZE];
   bit          mem_written [2][MEM_SIZE];

   ls_req_type  pending_requests [$];
   ls_rsp_type  expected_states [$];
   ls_rsp_type  want_state;
   int unsigned idle_pct = 16;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   cpu_8bit_load_store_unit_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_cur.op),
      .req_dest_reg       (req_cur.dst),
      .req_src_reg        (req_cur.src),
      .req_mem_address    (req_cur.addr),
      .req_write_value    (req_cur.wval),
      .rsp_valid          (rsp_valid),
      .rsp_reg_b          (rsp_reg_b),
      .rsp_reg_c          (rsp_reg_c),
      .rsp_reg_d          (rsp_reg_d),
      .rsp_reg_e          (rsp_reg_e),
      .rsp_reg_h          (rsp_reg_h),
      .rsp_reg_l          (rsp_reg_l),
      .rsp_reg_a          (rsp_reg_a),
      .rsp_prog_counter   (rsp_prog_counter),
      .rsp_peek_data      (rsp_peek_data),
      .rsp_machine_cycles (rsp_machine_cycles)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] reg_read(input int s, input logic [2:0] idx);
      return (idx <= c8lsu_pkg::REG_A) ? reg_img[s][idx] : 8'h00;
   endfunction

   function automatic void reg_write(input int s, input logic [2:0] idx, input logic [7:0] v);
      if (idx <= c8lsu_pkg::REG_A) begin
         reg_img[s][idx] = v;
      end
   endfunction

   function automatic logic [15:0] reg_pair(input int s, input logic [2:0] hi,
                                            input logic [2:0] lo);
      return {reg_img[s][hi], reg_img[s][lo]};
   endfunction

   function automatic logic [7:0] mem_read(input int s, input logic [15:0] a);
      return mem_img[s][a[MEM_BITS-1:0]];
   endfunction

   function automatic void mem_write(input int s, input logic [15:0] a, input logic [7:0] v);
      mem_img[s][a[MEM_BITS-1:0]] = v;
      mem_written[s][a[MEM_BITS-1:0]] = 1'b1;
   endfunction

   function automatic bit mem_known(input int s, input logic [15:0] a);
      return mem_written[s][a[MEM_BITS-1:0]];
   endfunction

   function automatic logic [7:0] fetch_pc_byte(input int s);
      logic [7:0] v;
      v = mem_read(s, pc_img[s]);
      pc_img[s] = pc_img[s] + 16'd1;
      return v;
   endfunction

   function automatic logic [15:0] fetch_pc_word(input int s);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = fetch_pc_byte(s);
      hi = fetch_pc_byte(s);
      return {hi, lo};
   endfunction

   // Executes one request on state copy s and returns the registers, PC, peeked byte and cost after it.
   function automatic ls_rsp_type run_load_store(input int s, input ls_req_type rq);
      ls_rsp_type r;
      logic [7:0] v;
      r = '0;
      case (rq.op)
         c8lsu_pkg::OP_LD_RR: begin
            reg_write(s, rq.dst, reg_read(s, rq.src));
            r.cycles = 3'd1;
         end
         c8lsu_pkg::OP_LD_R_HL: begin
            reg_write(s, rq.dst,
                      mem_read(s, reg_pair(s, c8lsu_pkg::REG_H, c8lsu_pkg::REG_L)));
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_HL_R: begin
            mem_write(s, reg_pair(s, c8lsu_pkg::REG_H, c8lsu_pkg::REG_L),
                      reg_read(s, rq.src));
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_R_IMM: begin
            reg_write(s, rq.dst, fetch_pc_byte(s));
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_HL_IMM: begin
            v = fetch_pc_byte(s);
            mem_write(s, reg_pair(s, c8lsu_pkg::REG_H, c8lsu_pkg::REG_L), v);
            r.cycles = 3'd3;
         end
         c8lsu_pkg::OP_LD_BC_A: begin
            mem_write(s, reg_pair(s, c8lsu_pkg::REG_B, c8lsu_pkg::REG_C),
                      reg_img[s][c8lsu_pkg::REG_A]);
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_DE_A: begin
            mem_write(s, reg_pair(s, c8lsu_pkg::REG_D, c8lsu_pkg::REG_E),
                      reg_img[s][c8lsu_pkg::REG_A]);
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_NN_A: begin
            mem_write(s, fetch_pc_word(s), reg_img[s][c8lsu_pkg::REG_A]);
            r.cycles = 3'd4;
         end
         c8lsu_pkg::OP_LD_A_BC: begin
            reg_img[s][c8lsu_pkg::REG_A] =
               mem_read(s, reg_pair(s, c8lsu_pkg::REG_B, c8lsu_pkg::REG_C));
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_A_DE: begin
            reg_img[s][c8lsu_pkg::REG_A] =
               mem_read(s, reg_pair(s, c8lsu_pkg::REG_D, c8lsu_pkg::REG_E));
            r.cycles = 3'd2;
         end
         c8lsu_pkg::OP_LD_A_NN: begin
            reg_img[s][c8lsu_pkg::REG_A] = mem_read(s, fetch_pc_word(s));
            r.cycles = 3'd4;
         end
         c8lsu_pkg::OP_POKE:   mem_write(s, rq.addr, rq.wval);
         c8lsu_pkg::OP_PEEK:   r.peek = mem_read(s, rq.addr);
         c8lsu_pkg::OP_SETPC:  pc_img[s] = rq.addr;
         c8lsu_pkg::OP_SETREG: reg_write(s, rq.dst, rq.wval);
         default: ;
      endcase
      r.b = reg_img[s][c8lsu_pkg::REG_B];
      r.c = reg_img[s][c8lsu_pkg::REG_C];
      r.d = reg_img[s][c8lsu_pkg::REG_D];
      r.e = reg_img[s][c8lsu_pkg::REG_E];
      r.h = reg_img[s][c8lsu_pkg::REG_H];
      r.l = reg_img[s][c8lsu_pkg::REG_L];
      r.a = reg_img[s][c8lsu_pkg::REG_A];
      r.pc = pc_img[s];
      return r;
   endfunction

   // Finds the first byte the request would read before anything was stored there.
   function automatic bit unwritten_read(input int s, input ls_req_type rq,
                                         output logic [15:0] hole);
      logic [15:0] pc;
      pc = pc_img[s];
      hole = '0;
      case (rq.op)
         c8lsu_pkg::OP_LD_R_HL: hole = reg_pair(s, c8lsu_pkg::REG_H, c8lsu_pkg::REG_L);
         c8lsu_pkg::OP_LD_A_BC: hole = reg_pair(s, c8lsu_pkg::REG_B, c8lsu_pkg::REG_C);
         c8lsu_pkg::OP_LD_A_DE: hole = reg_pair(s, c8lsu_pkg::REG_D, c8lsu_pkg::REG_E);
         c8lsu_pkg::OP_PEEK:    hole = rq.addr;
         c8lsu_pkg::OP_LD_R_IMM, c8lsu_pkg::OP_LD_HL_IMM: hole = pc;
         c8lsu_pkg::OP_LD_NN_A, c8lsu_pkg::OP_LD_A_NN: begin
            if (!mem_known(s, pc)) begin
               hole = pc;
               return 1'b1;
            end
            hole = pc + 16'd1;
            if (rq.op == c8lsu_pkg::OP_LD_A_NN && mem_known(s, hole)) begin
               hole = {mem_read(s, hole), mem_read(s, pc)};
            end
         end
         default: return 1'b0;
      endcase
      return !mem_known(s, hole);
   endfunction

   function automatic ls_req_type make_req(input logic [3:0] op, input logic [2:0] dst,
                                           input logic [2:0] src, input logic [15:0] addr,
                                           input logic [7:0] wval);
      ls_req_type rq;
      rq.op = op;
      rq.dst = dst;
      rq.src = src;
      rq.addr = addr;
      rq.wval = wval;
      return rq;
   endfunction

   // Three of four picks fall in small windows, one at the top of memory, so that
   // reads mostly find bytes stored by earlier requests.
   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return {13'h0000, 3'($urandom)};
         2:       return {13'h0800, 3'($urandom)};
         default: return {13'h1FFF, 3'($urandom)};
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'h40;
         2:       return 8'hFF;
         3:       return {5'b00000, 3'($urandom)};
         4:       return {5'b11111, 3'($urandom)};
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic ls_req_type rand_request();
      ls_req_type rq;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      rq = make_req(OP_UNUSED, 3'($urandom), 3'($urandom), pick_address(), 8'($urandom));
      if (pick < 62) begin
         rq.op = 4'($urandom_range(c8lsu_pkg::OP_LD_A_NN, c8lsu_pkg::OP_LD_RR));
      end else if (pick < 70) begin
         rq.op = c8lsu_pkg::OP_POKE;
         rq.wval = pick_byte();
      end else if (pick < 76) begin
         rq.op = c8lsu_pkg::OP_PEEK;
      end else if (pick < 80) begin
         rq.op = c8lsu_pkg::OP_SETPC;
      end else if (pick < 98) begin
         rq.op = c8lsu_pkg::OP_SETREG;
         rq.wval = pick_byte();
      end
      return rq;
   endfunction

   // Queues a request, preceded by pokes of any byte it would read unwritten.
   function automatic void queue_request(input ls_req_type rq);
      logic [15:0] hole;
      ls_req_type fill;
      while (unwritten_read(PLAN, rq, hole)) begin
         fill = make_req(c8lsu_pkg::OP_POKE, 3'($urandom), 3'($urandom), hole, pick_byte());
         void'(run_load_store(PLAN, fill));
         pending_requests.push_back(fill);
      end
      void'(run_load_store(PLAN, rq));
      pending_requests.push_back(rq);
   endfunction

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || start || expected_states.size() != 0);
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // Request driver: presents the next queued request once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_cur <= pending_requests.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each result, then predicts the request taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_states.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               want_state = expected_states.pop_front();
               compare_field("reg_b", rsp_reg_b, want_state.b);
               compare_field("reg_c", rsp_reg_c, want_state.c);
               compare_field("reg_d", rsp_reg_d, want_state.d);
               compare_field("reg_e", rsp_reg_e, want_state.e);
               compare_field("reg_h", rsp_reg_h, want_state.h);
               compare_field("reg_l", rsp_reg_l, want_state.l);
               compare_field("reg_a", rsp_reg_a, want_state.a);
               compare_field("prog_counter", rsp_prog_counter, want_state.pc);
               compare_field("peek_data", rsp_peek_data, want_state.peek);
               compare_field("machine_cycles", rsp_machine_cycles, want_state.cycles);
            end
         end
         if (start && !busy) begin
            expected_states.push_back(run_load_store(LIVE, req_cur));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("ERROR at %0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int s = 0; s < 2; s++) begin
         pc_img[s] = 16'h0000;
         for (int i = 0; i < 7; i++) begin
            reg_img[s][i] = 8'h00;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Pointer and PC wrap at the top of memory, register seven on both sides,
      // every load form and the unused op code.
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_A, 3'd0, 16'h0000, 8'hFF));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_H, 3'd0, 16'hFFFF, 8'hFF));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_L, 3'd0, 16'h0000, 8'hFF));
      queue_request(make_req(c8lsu_pkg::OP_POKE, 3'd0, 3'd0, 16'hFFFF, 8'hA5));
      queue_request(make_req(c8lsu_pkg::OP_LD_R_HL, c8lsu_pkg::REG_B, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_HL_R, 3'd0, REG_NONE, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_PEEK, 3'd0, 3'd0, 16'hFFFF, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_HL_R, 3'd0, c8lsu_pkg::REG_A, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_SETPC, 3'd0, 3'd0, 16'hFFFF, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_POKE, 3'd0, 3'd0, 16'h0000, 8'h12));
      queue_request(make_req(c8lsu_pkg::OP_POKE, 3'd0, 3'd0, 16'h12FF, 8'h5A));
      queue_request(make_req(c8lsu_pkg::OP_LD_A_NN, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_R_IMM, REG_NONE, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_RR, c8lsu_pkg::REG_C, c8lsu_pkg::REG_A,
                             16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_RR, c8lsu_pkg::REG_D, REG_NONE,
                             16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_RR, REG_NONE, c8lsu_pkg::REG_B,
                             16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_B, 3'd0, 16'h0000, 8'h40));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_C, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_BC_A, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, c8lsu_pkg::REG_E, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_DE_A, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_A_BC, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_A_DE, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_NN_A, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_LD_HL_IMM, 3'd0, 3'd0, 16'h0000, 8'h00));
      queue_request(make_req(c8lsu_pkg::OP_SETREG, REG_NONE, 3'd0, 16'h0000, 8'h77));
      queue_request(make_req(OP_UNUSED, REG_NONE, REG_NONE, 16'hFFFF, 8'hFF));
      queue_request(make_req(c8lsu_pkg::OP_PEEK, 3'd0, 3'd0, 16'h4000, 8'h00));
      wait_drained();

      repeat (400) queue_request(rand_request());
      wait_drained();
      idle_pct = 0;
      repeat (300) queue_request(rand_request());
      wait_drained();
      idle_pct = 16;
      repeat (300) queue_request(rand_request());
      wait_drained();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> cpu_8bit_load_store_unit_core.f
hw/rtl/c8lsu_pkg.sv
hw/rtl/c8lsu_front.sv
hw/rtl/c8lsu_queue.sv
hw/rtl/c8lsu_back.sv
hw/rtl/cpu_8bit_load_store_unit_core.sv
dv/cpu_8bit_load_store_unit_core_tb.sv
